[rtl/core/lfu_pkg.sv]
// Package for the LFU cache table: sizes, payload structs and the control/status
// bundles shared by the controller and the datapath. No dependencies.
package lfu_pkg;

   localparam int ENTRIES    = 16;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);
   localparam int COUNT_BITS = 16;
   localparam int STAMP_BITS = 48;
   localparam int CAP_BITS   = 5;

   localparam logic       CMD_GET = 1'b0;
   localparam logic       CMD_PUT = 1'b1;
   localparam logic [31:0] NO_VALUE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               command;
      logic [31:0]        key;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic [31:0]        evicted_key;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request, run search
      logic commit;   // apply update, emit result
   } lfu_cmd_type;

   // datapath -> controller (unused fields kept minimal)
   typedef struct packed {
      logic searched;
   } lfu_sts_type;

endpackage

[rtl/core/lfu_ctrl.sv]
// Controller for the LFU cache table: two-step sequence per transaction.
// Depends on lfu_pkg.
module lfu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  lfu_pkg::lfu_sts_type sts,
   output lfu_pkg::lfu_cmd_type cmd,
   output logic                 busy
);

   typedef enum logic [0:0] {ST_IDLE, ST_COMMIT} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_COMMIT;
         ST_COMMIT: if (sts.searched) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff == ST_COMMIT);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.commit = (state_ff == ST_COMMIT) && sts.searched;

endmodule

[rtl/core/lfu_datapath.sv]
// Datapath for the LFU cache table: entry registers, key match, victim tree.
// Depends on lfu_pkg.
module lfu_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  lfu_pkg::lfu_cmd_type    cmd,
   input  lfu_pkg::req_type        req,
   input  logic [lfu_pkg::CAP_BITS-1:0] capacity,
   output lfu_pkg::lfu_sts_type    sts,
   output lfu_pkg::rsp_type        rsp,
   output logic                    rsp_strobe
);

   localparam int N = lfu_pkg::ENTRIES;
   localparam int IB = lfu_pkg::IDX_BITS;
   localparam int CB = lfu_pkg::COUNT_BITS;
   localparam int SB = lfu_pkg::STAMP_BITS;
   localparam int OB = lfu_pkg::OCC_BITS;

   logic [N-1:0]      valid_ff;
   logic [31:0]       key_ff   [N];
   logic [31:0]       value_ff [N];
   logic [CB-1:0]     count_ff [N];
   logic [SB-1:0]     last_ff  [N];
   logic [SB-1:0]     stamp_ff;
   logic [OB-1:0]     occ_ff;

   lfu_pkg::req_type  req_ff;
   logic              hit_ff;
   logic [IB-1:0]     hit_idx_ff;
   logic              free_ok_ff;
   logic [IB-1:0]     free_idx_ff;
   logic              vic_ok_ff;
   logic [IB-1:0]     vic_idx_ff;
   logic              cap_zero_ff;
   logic              searched_ff;
   lfu_pkg::rsp_type  rsp_ff;
   logic              strobe_ff;

   // search, from live request
   logic              hit_c, free_c;
   logic [IB-1:0]     hit_idx_c, free_idx_c;
   logic [OB:0]       cap_c;

   always_comb begin
      hit_c = 1'b0;
      hit_idx_c = '0;
      free_c = 1'b0;
      free_idx_c = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req.key) begin
            hit_c = 1'b1;
            hit_idx_c = IB'(i);
         end
         if (!valid_ff[i]) begin
            free_c = 1'b1;
            free_idx_c = IB'(i);
         end
      end
      cap_c = (32'(capacity) > 32'(N)) ? (OB+1)'(N) : (OB+1)'(capacity);
   end

   // victim selection: registered leaves feed a comparator tree, left wins ties
   localparam int LEAVES = 1 << IB;
   logic [LEAVES-1:0]  tv   [IB+1];
   logic [CB-1:0]      tc   [IB+1][LEAVES];
   logic [SB-1:0]      ts   [IB+1][LEAVES];
   logic [IB-1:0]      ti   [IB+1][LEAVES];

   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         if (i < N) begin
            tv[0][i] = valid_ff[i];
            tc[0][i] = count_ff[i];
            ts[0][i] = last_ff[i];
         end else begin
            tv[0][i] = 1'b0;
            tc[0][i] = '0;
            ts[0][i] = '0;
         end
         ti[0][i] = IB'(i);
      end
      for (int l = 1; l <= IB; l++) begin
         for (int i = 0; i < LEAVES; i++) begin
            tv[l][i] = 1'b0;
            tc[l][i] = '0;
            ts[l][i] = '0;
            ti[l][i] = '0;
         end
         for (int i = 0; i < (LEAVES >> l); i++) begin
            if (tv[l-1][2*i] && (!tv[l-1][2*i+1] ||
                tc[l-1][2*i] < tc[l-1][2*i+1] ||
                (tc[l-1][2*i] == tc[l-1][2*i+1] && ts[l-1][2*i] <= ts[l-1][2*i+1]))) begin
               tv[l][i] = 1'b1;
               tc[l][i] = tc[l-1][2*i];
               ts[l][i] = ts[l-1][2*i];
               ti[l][i] = ti[l-1][2*i];
            end else begin
               tv[l][i] = tv[l-1][2*i+1];
               tc[l][i] = tc[l-1][2*i+1];
               ts[l][i] = ts[l-1][2*i+1];
               ti[l][i] = ti[l-1][2*i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req;
         hit_ff      <= hit_c;
         hit_idx_ff  <= hit_idx_c;
         free_ok_ff  <= free_c && ((OB+1)'(occ_ff) < cap_c);
         free_idx_ff <= free_idx_c;
         vic_ok_ff   <= tv[IB][0];
         vic_idx_ff  <= ti[IB][0];
         cap_zero_ff <= (cap_c == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         searched_ff <= 1'b0;
      end else begin
         searched_ff <= cmd.load;
      end
   end
   assign sts.searched = searched_ff;

   // commit
   logic              do_touch, do_insert, do_evict;
   logic [IB-1:0]     slot;
   logic [SB-1:0]     stamp_next;

   always_comb begin
      stamp_next = stamp_ff + SB'(1);
      do_touch  = hit_ff && (req_ff.command == lfu_pkg::CMD_GET || !cap_zero_ff);
      do_evict  = !hit_ff && req_ff.command == lfu_pkg::CMD_PUT && !cap_zero_ff &&
                  !free_ok_ff && vic_ok_ff;
      do_insert = !hit_ff && req_ff.command == lfu_pkg::CMD_PUT && !cap_zero_ff &&
                  (free_ok_ff || vic_ok_ff);
      slot      = free_ok_ff ? free_idx_ff : vic_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         stamp_ff  <= '0;
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.commit;
         if (cmd.commit && (do_touch || do_insert)) begin
            stamp_ff <= stamp_next;
         end
         if (cmd.commit && do_insert) begin
            valid_ff[slot] <= 1'b1;
            if (!do_evict) begin
               occ_ff <= occ_ff + OB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.hit         <= hit_ff;
         rsp_ff.read_value  <= (req_ff.command == lfu_pkg::CMD_GET && hit_ff) ?
                               value_ff[hit_idx_ff] : lfu_pkg::NO_VALUE;
         rsp_ff.evicted     <= do_evict;
         rsp_ff.evicted_key <= do_evict ? key_ff[vic_idx_ff] : 32'd0;
         if (do_touch) begin
            if (count_ff[hit_idx_ff] != '1) begin
               count_ff[hit_idx_ff] <= count_ff[hit_idx_ff] + CB'(1);
            end
            last_ff[hit_idx_ff] <= stamp_next;
            if (req_ff.command == lfu_pkg::CMD_PUT) begin
               value_ff[hit_idx_ff] <= req_ff.write_value;
            end
         end
         if (do_insert) begin
            key_ff[slot]   <= req_ff.key;
            value_ff[slot] <= req_ff.write_value;
            count_ff[slot] <= CB'(1);
            last_ff[slot]  <= stamp_next;
         end
      end
   end

   assign rsp        = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

[rtl/core/lfu_cache_table_top.sv]
// Top level of the LFU cache table: capacity register, controller, datapath.
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath.
//
// Usage:
//  - Command channel: drive req_payload and raise start; the transaction is
//    taken at a clock edge where start is high and busy is low.
//  - The search step checks all entries in parallel (key match, first free slot,
//    least-count / oldest victim through a comparator tree) into registers.
//  - The commit step applies the update; the result appears on rsp_payload with
//    rsp_strobe high for exactly one cycle, the cycle after that.
//  - busy is high during the commit cycle, so no new transaction is taken
//    until the previous one has committed.
//  - The receiver cannot stall: each result is shown once and must be taken.
//  - csr_write_enable/csr_write_data load the 5-bit capacity; write only when
//    idle. Values above the table size act as the table size; zero blocks puts.
//  - Reset (synchronous, active high) empties the table, clears the recency
//    stamp and occupancy, and sets capacity to 16.
module lfu_cache_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lfu_pkg::req_type              req_payload,
   output logic                          rsp_strobe,
   output lfu_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [lfu_pkg::CAP_BITS-1:0]  csr_write_data
);

   logic [lfu_pkg::CAP_BITS-1:0] capacity_ff;
   lfu_pkg::lfu_cmd_type         cmd;
   lfu_pkg::lfu_sts_type         sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lfu_pkg::CAP_BITS'(16);
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   lfu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   lfu_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_payload),
      .capacity   (capacity_ff),
      .sts        (sts),
      .rsp        (rsp_payload),
      .rsp_strobe (rsp_strobe)
   );

   // A transaction accepted now yields its strobe once its search and commit steps are both registered.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("missing response strobe");

   // Only puts can report an eviction.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.evicted) |-> (rsp_payload.read_value == lfu_pkg::NO_VALUE))
      else $error("eviction with read value");

   // Load and commit never coincide.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.commit))
      else $error("load and commit overlap");

endmodule
